// ===== rtl/l2vn_pkg.sv =====
// ----------------------------------------------------------------------------
// l2vn_pkg
// Shared constants, controller states and control structs of the normalizer.
// ----------------------------------------------------------------------------
package l2vn_pkg;

  localparam int MAX_LEN   = 64;
  localparam int ADDR_W    = $clog2(MAX_LEN);
  localparam int CNT_W     = $clog2(MAX_LEN + 1);
  localparam int SAMPLE_W  = 16;
  localparam int SUM_W     = 37;
  localparam int T_W       = SUM_W + 1;
  localparam int ACC_W     = 76;
  localparam int BIT_W     = 4;
  localparam int EPS_W     = 16;
  localparam logic [EPS_W-1:0] EPS_RESET = 16'd107;
  localparam logic [BIT_W-1:0] BIT_TOP   = 4'd15;

  typedef enum logic [2:0] {
    S_IN,
    S_RD,
    S_INIT,
    S_ITER,
    S_OUT
  } state_t;

  typedef struct packed {
    logic accept;
    logic rd;
    logic init;
    logic iter;
    logic advance;
  } cmd_t;

  typedef struct packed {
    logic iter_done;
    logic last_elem;
  } status_t;

endpackage

// ===== rtl/l2vn_ctrl.sv =====
// ----------------------------------------------------------------------------
// l2vn_ctrl
// Sequencer: collects a vector, then steps each element through the scaler.
// ----------------------------------------------------------------------------
module l2vn_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              last_in,
  output logic              out_valid,
  input  logic              out_stall,
  input  l2vn_pkg::status_t status,
  output l2vn_pkg::cmd_t    cmd
);
  import l2vn_pkg::*;

  state_t state, state_next;
  logic   in_beat;

  assign in_beat = in_valid && (state == S_IN);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IN;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IN:   if (in_beat && last_in) state_next = S_RD;
      S_RD:   state_next = S_INIT;
      S_INIT: state_next = S_ITER;
      S_ITER: if (status.iter_done) state_next = S_OUT;
      S_OUT: begin
        if (!out_stall) state_next = status.last_elem ? S_IN : S_RD;
      end
      default: state_next = S_IN;
    endcase
  end

  always_comb begin
    cmd         = '0;
    in_stall    = 1'b1;
    out_valid   = 1'b0;
    unique case (state)
      S_IN: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      S_RD:   cmd.rd   = 1'b1;
      S_INIT: cmd.init = 1'b1;
      S_ITER: cmd.iter = 1'b1;
      S_OUT: begin
        out_valid   = 1'b1;
        cmd.advance = !out_stall;
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/l2vn_datapath.sv =====
// ----------------------------------------------------------------------------
// l2vn_datapath
// Element buffer, square accumulator and bit-serial inverse-root scaler.
// ----------------------------------------------------------------------------
module l2vn_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  l2vn_pkg::cmd_t                 cmd,
  output l2vn_pkg::status_t              status,
  input  logic [l2vn_pkg::EPS_W-1:0]     epsilon,
  input  logic signed [l2vn_pkg::SAMPLE_W-1:0] sample,
  input  logic                           last_in,
  output logic signed [l2vn_pkg::SAMPLE_W-1:0] normalized,
  output logic                           last_out,
  output logic                           overflow
);
  import l2vn_pkg::*;

  logic [SAMPLE_W-1:0] mem [MAX_LEN];
  logic [SAMPLE_W-1:0] rdata;

  logic [CNT_W-1:0]  count, n_len;
  logic [SUM_W-1:0]  sum;
  logic              ovf_seen;
  logic [T_W-1:0]    t;
  logic [ADDR_W-1:0] k;

  logic [SAMPLE_W-1:0] in_mag;
  logic                room;
  logic [CNT_W-1:0]    count_new;
  logic [SUM_W-1:0]    sum_new;
  logic                ovf_new;

  logic                neg, zero;
  logic [SAMPLE_W-1:0] emag;
  logic [ACC_W-1:0]    x, y;
  logic [SAMPLE_W-1:0] q;
  logic [BIT_W-1:0]    b;
  logic [BIT_W:0]      bx;

  logic [ACC_W-1:0]    tw, lhs_p, lhs_m, rhs;
  logic                fits, done;
  logic [SAMPLE_W-1:0] q_fin, res;
  logic [SAMPLE_W-1:0] bitv;

  assign in_mag    = sample[SAMPLE_W-1] ? SAMPLE_W'(-sample) : SAMPLE_W'(sample);
  assign room      = count < CNT_W'(MAX_LEN);
  assign count_new = room ? count + CNT_W'(1) : count;
  assign sum_new   = room ? sum + SUM_W'(32'(in_mag) * 32'(in_mag)) : sum;
  assign ovf_new   = ovf_seen || !room;

  always_ff @(posedge clk) begin
    if (cmd.accept && room) mem[count[ADDR_W-1:0]] <= sample;
    if (cmd.rd) rdata <= mem[k];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      sum      <= '0;
      ovf_seen <= 1'b0;
      k        <= '0;
    end else if (cmd.accept) begin
      k <= '0;
      if (last_in) begin
        count    <= '0;
        sum      <= '0;
        ovf_seen <= 1'b0;
      end else begin
        count    <= count_new;
        sum      <= sum_new;
        ovf_seen <= ovf_new;
      end
    end else if (cmd.advance) begin
      k <= k + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && last_in) begin
      t        <= T_W'(sum_new) + T_W'(epsilon);
      n_len    <= count_new;
      overflow <= ovf_new;
    end
  end

  // Test (2c-1)^2 * t <= 4a^2 with c = q + 2^b, using x = t*q^2, y = t*q.
  assign tw    = ACC_W'(t);
  assign bx    = {1'b0, b};
  assign bitv  = SAMPLE_W'(1) << b;
  assign lhs_p = (x << 2) + (y << (bx + (BIT_W+1)'(3))) + (tw << (2 * b + 2)) + tw;
  assign lhs_m = (y << 2) + (tw << (bx + (BIT_W+1)'(2)));
  assign rhs   = ACC_W'(32'(emag) * 32'(emag)) << 32;
  assign fits  = !zero && ((lhs_p - lhs_m) <= rhs);
  assign done  = zero || (b == '0) || ((b == BIT_TOP) && fits);
  assign q_fin = zero ? '0 : (fits ? (q | bitv) : q);
  assign res   = neg ? SAMPLE_W'(-q_fin)
                     : (q_fin[SAMPLE_W-1] ? {1'b0, {(SAMPLE_W-1){1'b1}}} : q_fin);

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      neg  <= rdata[SAMPLE_W-1];
      emag <= rdata[SAMPLE_W-1] ? SAMPLE_W'(-rdata) : rdata;
      zero <= (rdata == '0);
      x    <= '0;
      y    <= '0;
      q    <= '0;
      b    <= BIT_TOP;
    end else if (cmd.iter) begin
      if (fits) begin
        x <= x + (y << (bx + (BIT_W+1)'(1))) + (tw << (2 * b));
        y <= y + (tw << b);
        q <= q | bitv;
      end
      b <= b - BIT_W'(1);
      if (done) begin
        normalized <= res;
        last_out   <= ({1'b0, k} + CNT_W'(1)) == n_len;
      end
    end
  end

  assign status.iter_done = done;
  assign status.last_elem = ({1'b0, k} + CNT_W'(1)) == n_len;

endmodule

// ===== rtl/l2_vector_normalizer.sv =====
// ----------------------------------------------------------------------------
// l2_vector_normalizer
// After the last input beat each result takes a buffer read, a setup step
// and the bit-serial inverse-root scaler (one quotient bit per cycle), then
// one output beat. Input: 1 beat/cycle while a vector is collected;
// in_stall holds input until every result of the vector has gone out.
// Reset clears counters, sum and controller; epsilon resets to 107.
// ----------------------------------------------------------------------------
module l2_vector_normalizer (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [l2vn_pkg::SAMPLE_W-1:0] sample,
  input  logic                                 last_in,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [l2vn_pkg::SAMPLE_W-1:0] normalized,
  output logic                                 last_out,
  output logic                                 overflow,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [l2vn_pkg::EPS_W-1:0]           cfg_data
);
  import l2vn_pkg::*;

  cmd_t             cmd;
  status_t          status;
  logic [EPS_W-1:0] epsilon;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      epsilon <= EPS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      epsilon <= cfg_data;
    end
  end

  l2vn_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .last_in   (last_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  l2vn_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .epsilon    (epsilon),
    .sample     (sample),
    .last_in    (last_in),
    .normalized (normalized),
    .last_out   (last_out),
    .overflow   (overflow)
  );

endmodule

// ===== sim/l2_vector_normalizer_test.sv =====
// ----------------------------------------------------------------------------
// l2_vector_normalizer_test
// Self-checking bench for the L2 vector normalizer. Directed single-element
// and short vectors, then random vectors (some past buffer depth) under
// several epsilon settings, with random idle on both beat channels. Results
// are scored in order against a bit-exact inverse-root predictor.
// ----------------------------------------------------------------------------
module l2_vector_normalizer_test;
  import l2vn_pkg::*;

  localparam int CFG_INDEX = 0;
  localparam int WDOG_LIMIT = 5000;

  typedef struct {
    logic signed [SAMPLE_W-1:0] norm;
    logic                       last;
    logic                       ovf;
  } result_t;

  typedef struct {
    int  smp;
    bit  last;
    bit  typed;
    int  norm;
  } row_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0, last_in = 0, out_stall = 0, cfg_valid = 0;
  logic signed [SAMPLE_W-1:0] sample = '0;
  logic [EPS_W-1:0] cfg_data = '0;
  wire in_stall, out_valid, last_out, overflow, cfg_ready;
  wire signed [SAMPLE_W-1:0] normalized;

  l2_vector_normalizer uut (.*);

  always #5 clk = ~clk;

  // predictor state
  logic [SAMPLE_W-1:0] elem_buf [MAX_LEN];
  logic [SUM_W-1:0]    sq_sum = '0;
  int                  elem_cnt = 0;
  bit                  dropped = 0;
  logic [EPS_W-1:0]    eps = EPS_RESET;

  result_t expq[$];
  int errors = 0, mismatches = 0;
  bit quiet = 0;
  int wdog = 0;

  function automatic bit mag_ok(longint unsigned q, longint unsigned a,
                                longint unsigned t);
    longint unsigned m;
    if (q == 0) return 1;
    m = (2 * q - 1) * (2 * q - 1);
    return t <= (4 * a * a) / m;
  endfunction

  function automatic longint unsigned inv_root_mag(longint unsigned a,
                                                   longint unsigned t);
    longint unsigned q;
    longint unsigned c;
    q = 0;
    if (a == 0) return 0;
    if (mag_ok(32768, a, t)) return 32768;
    for (int b = 14; b >= 0; b--) begin
      c = q | (64'd1 << b);
      if (mag_ok(c, a, t)) q = c;
    end
    return q;
  endfunction

  task automatic absorb(logic [SAMPLE_W-1:0] s, bit lst, bit typed, int tv);
    longint unsigned mag, q, t;
    result_t r;
    if (elem_cnt < MAX_LEN) begin
      mag = s[15] ? 17'h10000 - s : s;
      elem_buf[elem_cnt] = s;
      elem_cnt++;
      sq_sum = sq_sum + SUM_W'(mag * mag);
    end else begin
      dropped = 1;
    end
    if (!lst) return;
    t = sq_sum + eps;
    for (int k = 0; k < elem_cnt; k++) begin
      mag = elem_buf[k][15] ? 17'h10000 - elem_buf[k] : elem_buf[k];
      q = inv_root_mag(mag << 15, t);
      if (elem_buf[k][15]) r.norm = 16'(17'h10000 - q);
      else r.norm = (q > 32767) ? 16'sd32767 : 16'(q);
      if (typed) r.norm = 16'(tv);
      r.last = (k + 1 == elem_cnt);
      r.ovf = dropped;
      expq.push_back(r);
    end
    elem_cnt = 0;
    sq_sum = '0;
    dropped = 0;
  endtask

  task automatic send_beat(int s, bit lst, bit typed = 0, int tv = 0);
    while (!quiet && $urandom_range(99) < 24) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    sample <= SAMPLE_W'(s);
    last_in <= lst;
    do @(posedge clk); while (in_stall);
    absorb(16'(s), lst, typed, tv);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (expq.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_eps(logic [EPS_W-1:0] v);
    cfg_valid <= 1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    eps = v;
  endtask

  function automatic int rand_sample();
    case ($urandom_range(5))
      0: return $urandom_range(1) ? 32767 : -32768;
      1: return int'($urandom_range(16)) - 8;
      2: return 0;
      default: return int'($signed(16'($urandom)));
    endcase
  endfunction

  task automatic random_vectors(int items);
    int len;
    int sent;
    sent = 0;
    while (sent < items) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 8);
      for (int i = 0; i < len; i++) send_beat(rand_sample(), i == len - 1);
      sent += len;
    end
  endtask

  // output side
  always @(posedge clk) begin
    result_t e;
    out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 24);
    if (!rst && out_valid && !out_stall) begin
      if (expq.size() == 0) begin
        errors++;
        if (++mismatches <= 10) $display("unexpected beat: norm=%0d", normalized);
      end else begin
        e = expq.pop_front();
        if (normalized !== e.norm || last_out !== e.last || overflow !== e.ovf) begin
          errors++;
          if (++mismatches <= 10)
            $display("mismatch: exp norm=%0d last=%0b ovf=%0b got norm=%0d last=%0b ovf=%0b",
                     e.norm, e.last, e.ovf, normalized, last_out, overflow);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      wdog <= 0;
    else
      wdog <= wdog + 1;
    if (wdog > WDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  row_t rows[] = '{
    '{32767, 1, 1, 32767},
    '{-32768, 1, 1, -32768},
    '{0, 1, 1, 0},
    '{1, 1, 0, 0},
    '{-1, 1, 0, 0},
    '{3, 0, 0, 0},
    '{4, 1, 0, 0},
    '{32767, 0, 0, 0},
    '{-32768, 0, 0, 0},
    '{0, 0, 0, 0},
    '{12345, 1, 0, 0},
    '{-7, 0, 0, 0},
    '{7, 1, 0, 0}
  };

  initial begin
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    foreach (rows[i]) send_beat(rows[i].smp, rows[i].last, rows[i].typed, rows[i].norm);
    drain();

    set_eps(16'd0);
    send_beat(0, 0);
    send_beat(0, 1, 1, 0);
    random_vectors(80);
    drain();

    set_eps(16'hFFFF);
    quiet = 1;
    random_vectors(80);
    drain();
    quiet = 0;

    set_eps(16'($urandom));
    random_vectors(80);
    drain();

    set_eps(16'($urandom_range(1, 255)));
    random_vectors(80);
    drain();

    set_eps(EPS_RESET);
    random_vectors(80);
    drain();

    errors += expq.size();
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
